// ===== sv/pud_pkg.sv =====
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types, codes and the helper function of the percent URL decoder.
// ----------------------------------------------------------------------------
package pud_pkg;

    // Decoder phases.
    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ESC1  = 2'd1;
    localparam logic [1:0] PH_ESC2  = 2'd2;
    localparam logic [1:0] PH_QUERY = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_RAW = 2'd1;
    localparam logic [1:0] KIND_SEP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PLUS_AS_SPACE  = 2'd0;
    localparam logic [1:0] REG_SPLIT_AT_QUERY = 2'd1;
    localparam logic [1:0] REG_LEAD_NULL      = 2'd2;

    // Character constants.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] NIB_OFFSET = 8'd9;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic plus_as_space;
        logic split_at_query;
        logic lead_null;
    } t_cfg;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] high_nibble;
        logic       started;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic [1:0] n_res;
        t_result    res0;
        t_result    res1;
        t_state     next_state;
    } t_step;

    // Hex digit value without any checking of the character.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] sum;
        sum = c + NIB_OFFSET;
        if (c < CH_UPPER_A) begin
            return c[3:0];
        end
        return sum[3:0];
    endfunction

endpackage

// ===== sv/pud_in_if.sv =====
// ----------------------------------------------------------------------------
// pud_in_if
// Input channel of the decoder: one encoded byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface pud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/pud_out_if.sv =====
// ----------------------------------------------------------------------------
// pud_out_if
// Output channel of the decoder: one result byte with its kind and last flag.
// ----------------------------------------------------------------------------
interface pud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_last;

    modport source (output valid, output out_byte, output out_kind,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input out_last, output ready);
endinterface

// ===== sv/percent_url_decoder_top.sv =====
// ----------------------------------------------------------------------------
// percent_url_decoder_top
// Streaming percent decoder for URL path and query components.
// ----------------------------------------------------------------------------
// A byte passes through the input register and then the result queue.
// Throughput: one input item per cycle while the queue has room; the output
// port moves one item per cycle, so a string's leading zero byte adds an item.
// Reset (synchronous, active low) empties the input register and the result
// queue, clears the decoder state and loads the register defaults
// (plus_as_space = 1, split_at_query = 0, lead_null = 0).
// ----------------------------------------------------------------------------
module percent_url_decoder_top
    import pud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic       i_cfg_data,
    pud_in_if.sink     i_in,
    pud_out_if.source  o_out
);

    // Configuration registers. Index three is not a register and is ignored.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{plus_as_space: 1'b1, split_at_query: 1'b0, lead_null: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PLUS_AS_SPACE:  r_cfg.plus_as_space  <= i_cfg_data;
                REG_SPLIT_AT_QUERY: r_cfg.split_at_query <= i_cfg_data;
                REG_LEAD_NULL:      r_cfg.lead_null      <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Input register. It is refilled in the same cycle that its item is
    // decoded, so a new byte can enter on every clock while the queue has room.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       advance;
    logic       in_acc;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    // Decoder state and the decode logic for the byte in the input register.
    t_state r_state;
    t_step  step;

    pud_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_step  (step)
    );

    // Results land in a short queue that decouples the two sides. A byte is
    // decoded only when every result it causes fits into the queue.
    t_result           q_head;
    logic              q_nonempty;
    logic [QCNT_W-1:0] q_free;
    logic              pop;
    logic [1:0]        push_n;

    assign advance = r_in_vld && (q_free >= QCNT_W'(step.n_res));
    assign push_n  = advance ? step.n_res : 2'd0;
    assign pop     = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_PLAIN, high_nibble: 4'd0, started: 1'b0};
        end else if (advance) begin
            r_state <= step.next_state;
        end
    end

    pud_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_res0     (step.res0),
        .i_res1     (step.res1),
        .i_pop      (pop),
        .o_head     (q_head),
        .o_nonempty (q_nonempty),
        .o_free     (q_free)
    );

    assign o_out.valid    = q_nonempty;
    assign o_out.out_byte = q_head.out_byte;
    assign o_out.out_kind = q_head.out_kind;
    assign o_out.out_last = q_head.out_last;

    // A byte that ends a string always produces at least one result.
    a_last_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |-> (step.n_res != 2'd0))
        else $error("string end decoded without a result");

    // After the end of a string the decoder is back in its plain phase.
    a_last_clears_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (!r_state.started && r_state.phase == PH_PLAIN))
        else $error("decoder state not cleared at string end");

    // The queue never takes more results than it has room for.
    a_queue_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> (QCNT_W'(push_n) <= q_free))
        else $error("result queue overflow");

    // The input register only drains when its byte has been decoded.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("input item lost while stalled");

endmodule

// ===== sv/pud_step.sv =====
// ----------------------------------------------------------------------------
// pud_step
// Decode logic for one byte: results it causes and the next decoder state.
// ----------------------------------------------------------------------------
module pud_step
    import pud_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_step      o_step
);

    logic    lead;
    logic    main_vld;
    t_result main_res;
    t_state  nxt;

    always_comb begin
        lead     = !i_state.started && i_cfg.lead_null;
        main_vld = 1'b1;
        main_res = '{out_byte: i_byte, out_kind: KIND_DEC, out_last: i_last};
        nxt      = i_state;
        nxt.started = 1'b1;

        unique case (i_state.phase)
            PH_ESC1: begin
                if (i_last) begin
                    main_res.out_byte = 8'h00;
                end else begin
                    main_vld        = 1'b0;
                    nxt.high_nibble = nibble_of(i_byte);
                    nxt.phase       = PH_ESC2;
                end
            end
            PH_ESC2: begin
                main_res.out_byte = {i_state.high_nibble, nibble_of(i_byte)};
                nxt.phase         = PH_PLAIN;
            end
            PH_QUERY: begin
                main_res.out_kind = KIND_RAW;
            end
            default: begin
                priority if (i_byte == CH_PERCENT) begin
                    if (i_last) begin
                        main_res.out_byte = 8'h00;
                    end else begin
                        main_vld  = 1'b0;
                        nxt.phase = PH_ESC1;
                    end
                end else if (i_byte == CH_QUEST && i_cfg.split_at_query) begin
                    main_res.out_byte = 8'h00;
                    main_res.out_kind = KIND_SEP;
                    nxt.phase         = PH_QUERY;
                end else if (i_byte == CH_PLUS && i_cfg.plus_as_space) begin
                    main_res.out_byte = CH_SPACE;
                end else begin
                    main_res.out_byte = i_byte;
                end
            end
        endcase

        // The end of a string puts the state back to its reset values.
        if (i_last) begin
            nxt = '{phase: PH_PLAIN, high_nibble: 4'd0, started: 1'b0};
        end

        o_step.next_state = nxt;
        o_step.n_res      = {1'b0, lead} + {1'b0, main_vld};
        if (lead) begin
            o_step.res0 = '{out_byte: 8'h00, out_kind: KIND_DEC, out_last: 1'b0};
            o_step.res1 = main_res;
        end else begin
            o_step.res0 = main_res;
            o_step.res1 = main_res;
        end
    end

endmodule

// ===== sv/pud_outq.sv =====
// ----------------------------------------------------------------------------
// pud_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module pud_outq
    import pud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  t_result           i_res0,
    input  t_result           i_res1,
    input  logic              i_pop,
    output t_result           o_head,
    output logic              o_nonempty,
    output logic [QCNT_W-1:0] o_free
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] wr_plus1;

    assign wr_plus1   = r_wr + QPTR_W'(1);
    assign o_head     = r_mem[r_rd];
    assign o_nonempty = (r_count != '0);
    // Room that a push may use in this cycle, counting the slot freed by a pop.
    assign o_free     = QCNT_W'(QDEPTH) - r_count + QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_plus1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push_n);
            r_rd    <= r_rd + QPTR_W'(i_pop);
            r_count <= r_count + QCNT_W'(i_push_n) - QCNT_W'(i_pop);
        end
    end

endmodule
